>>> rtl/bcsr_pkg.sv
// Package with the types, constants and helper function of the block-CSR matrix-vector unit.
package bcsr_pkg;

  localparam int NODES_DEF      = 4096;
  localparam int MAX_DOF_DEF    = 4;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam int COL_W      = 12;
  localparam int COMP_W     = 2;
  localparam int Q_W        = 32;
  localparam int ACC_W      = 48;
  localparam int PROD_W     = 64;
  localparam int FRAC_W     = 16;
  localparam int DOF_W      = 4;
  localparam int CFG_DOF_W  = 3;
  localparam int ROWCNT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 13'h1000;

  localparam logic signed [ACC_W-1:0] ACC_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN   = 48'sh8000_0000_0000;
  localparam logic signed [ACC_W-1:0] Q_MAX_ACC = 48'sh0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Q_MIN_ACC = 48'shFFFF_8000_0000;
  localparam logic signed [Q_W-1:0]   Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0]   Q_MIN     = 32'sh8000_0000;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sh0000_0000_0000_8000;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_COEF  = 2'd1,
    MODE_CLOSE = 2'd2
  } bcsr_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_DOF   = 2'd0,
    REG_IN_DOF    = 2'd1,
    REG_ROW_COUNT = 2'd2
  } bcsr_reg_t;

  typedef struct packed {
    bcsr_mode_t              mode;
    logic [COL_W-1:0]        column;
    logic [COMP_W-1:0]       in_comp;
    logic [COMP_W-1:0]       out_comp;
    logic signed [Q_W-1:0]   value;
    logic                    end_of_row;
  } bcsr_in_t;

  typedef struct packed {
    logic [COL_W-1:0]        row;
    logic [COMP_W-1:0]       comp;
    logic signed [Q_W-1:0]   sum;
    logic                    saturated;
    logic                    last;
  } bcsr_out_t;

  typedef struct packed {
    logic signed [Q_W-1:0]   value;
    logic signed [Q_W-1:0]   vec;
    logic [COMP_W-1:0]       oc;
    logic                    mac;
    logic                    close;
  } bcsr_work_t;

  typedef struct packed {
    logic [DOF_W-1:0]        out_dof;
    logic [DOF_W-1:0]        in_dof;
    logic [ROWCNT_W-1:0]     row_count;
  } bcsr_cfg_t;

  function automatic logic [DOF_W-1:0] eff_dof(input logic [CFG_DOF_W-1:0] d,
                                               input logic [DOF_W-1:0] max_dof);
    logic [DOF_W-1:0] dx;
    dx = DOF_W'(d);
    if (dx == '0) begin
      eff_dof = DOF_W'(1);
    end else if (dx > max_dof) begin
      eff_dof = max_dof;
    end else begin
      eff_dof = dx;
    end
  endfunction

endpackage

>>> rtl/bcsr_fifo.sv
// Small register queue used between the front and back parts and on the result side.
module bcsr_fifo
  import bcsr_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/bcsr_front.sv
// Front part: accepts items, classifies them and owns the vector memory.
module bcsr_front
  import bcsr_pkg::*;
#(
  parameter int NODES   = NODES_DEF,
  parameter int MAX_DOF = MAX_DOF_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bcsr_cfg_t  cfg,
  input  logic       in_push,
  input  bcsr_in_t   in_item,
  output logic       in_full,
  input  logic       q_full,
  output logic       q_push,
  output bcsr_work_t q_work
);

  localparam int ENTRIES = NODES * MAX_DOF;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic signed [Q_W-1:0] mem [ENTRIES];
  logic signed [Q_W-1:0] rdata_r;

  logic                  accept;
  logic                  ic_ok;
  logic                  oc_ok;
  logic                  node_ok;
  logic                  mac;
  logic                  close;
  logic                  wr_en;
  logic [31:0]           addr_full;
  logic [AW-1:0]         addr;

  logic                  f_vld_r, f_vld_nxt;
  logic signed [Q_W-1:0] f_value_r;
  logic [COMP_W-1:0]     f_oc_r;
  logic                  f_mac_r;
  logic                  f_close_r;
  logic                  f_rd_ok_r;

  assign in_full = f_vld_r & q_full;
  assign q_push  = f_vld_r & ~q_full;
  assign accept  = in_push & ~in_full;

  assign ic_ok     = (DOF_W'(in_item.in_comp) < cfg.in_dof);
  assign oc_ok     = (DOF_W'(in_item.out_comp) < cfg.out_dof);
  assign node_ok   = (32'(in_item.column) < 32'(NODES));
  assign addr_full = 32'(in_item.column) * 32'(MAX_DOF) + 32'(in_item.in_comp);
  assign addr      = addr_full[AW-1:0];
  assign wr_en     = accept & (in_item.mode == MODE_LOAD) & ic_ok & node_ok;

  always_comb begin
    mac   = 1'b0;
    close = 1'b0;
    case (in_item.mode)
      MODE_COEF: begin
        mac   = ic_ok & oc_ok;
        close = in_item.end_of_row;
      end
      MODE_CLOSE: begin
        close = 1'b1;
      end
      default: begin
        mac   = 1'b0;
        close = 1'b0;
      end
    endcase
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (q_push) begin
      f_vld_nxt = 1'b0;
    end
    if (accept) begin
      f_vld_nxt = mac | close;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_value_r <= in_item.value;
      f_oc_r    <= in_item.out_comp;
      f_mac_r   <= mac;
      f_close_r <= close;
      f_rd_ok_r <= node_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= in_item.value;
    end
    if (accept) begin
      rdata_r <= mem[addr];
    end
  end

  assign q_work.value = f_value_r;
  assign q_work.vec   = f_rd_ok_r ? rdata_r : '0;
  assign q_work.oc    = f_oc_r;
  assign q_work.mac   = f_mac_r;
  assign q_work.close = f_close_r;

endmodule

>>> rtl/bcsr_back.sv
// Back part: multiply, round, accumulate and emit the row results.
module bcsr_back
  import bcsr_pkg::*;
#(
  parameter int MAX_DOF = MAX_DOF_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bcsr_cfg_t  cfg,
  input  logic       q_empty,
  input  bcsr_work_t q_work,
  output logic       q_pop,
  input  logic       oq_full,
  output logic       oq_push,
  output bcsr_out_t  oq_item
);

  localparam int AIW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;

  logic                     adv;
  logic                     b1_vld_r, b2_vld_r, b3_vld_r;
  bcsr_work_t               b1_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [COMP_W-1:0]        b2_oc_r, b3_oc_r;
  logic                     b2_mac_r, b3_mac_r;
  logic                     b2_close_r, b3_close_r;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [ACC_W-1:0]  term_nxt;
  logic signed [ACC_W-1:0]  term_r;

  logic signed [ACC_W-1:0]  acc_r [MAX_DOF];
  logic signed [ACC_W-1:0]  acc_upd [MAX_DOF];
  logic signed [ACC_W-1:0]  snap_r [MAX_DOF];
  logic [AIW-1:0]           acc_idx;
  logic signed [ACC_W:0]    acc_sum_w;
  logic signed [ACC_W-1:0]  acc_sum;

  logic                     row_close;
  logic [COL_W-1:0]         row_r, row_nxt;
  logic [ROWCNT_W-1:0]      row_inc;

  logic                     emit_busy_r, emit_busy_nxt;
  logic [DOF_W-1:0]         emit_idx_r, emit_idx_nxt;
  logic [DOF_W-1:0]         emit_n_r;
  logic [COL_W-1:0]         emit_row_r;
  logic                     emit_last;
  logic signed [ACC_W-1:0]  acc_e;

  assign adv   = ~(b3_vld_r & b3_close_r & emit_busy_r);
  assign q_pop = adv & ~q_empty;

  assign prod_nxt = b1_r.value * b1_r.vec;
  assign rnd_full = prod_r + ROUND_HALF;
  assign term_nxt = ACC_W'(rnd_full >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      b3_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r <= ~q_empty;
      b2_vld_r <= b1_vld_r;
      b3_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r       <= q_work;
      prod_r     <= prod_nxt;
      b2_oc_r    <= b1_r.oc;
      b2_mac_r   <= b1_r.mac;
      b2_close_r <= b1_r.close;
      term_r     <= term_nxt;
      b3_oc_r    <= b2_oc_r;
      b3_mac_r   <= b2_mac_r;
      b3_close_r <= b2_close_r;
    end
  end

  assign acc_idx   = AIW'(b3_oc_r);
  assign acc_sum_w = {acc_r[acc_idx][ACC_W-1], acc_r[acc_idx]} + {term_r[ACC_W-1], term_r};

  always_comb begin
    if (acc_sum_w[ACC_W] != acc_sum_w[ACC_W-1]) begin
      acc_sum = acc_sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sum = acc_sum_w[ACC_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DOF; i++) begin
      acc_upd[i] = acc_r[i];
    end
    if (b3_mac_r) begin
      acc_upd[acc_idx] = acc_sum;
    end
  end

  assign row_close = adv & b3_vld_r & b3_close_r;

  assign row_inc = {1'b0, row_r} + ROWCNT_W'(1);
  always_comb begin
    if ((row_inc >= cfg.row_count) || row_inc[ROWCNT_W-1]) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      for (int i = 0; i < MAX_DOF; i++) begin
        acc_r[i] <= '0;
      end
    end else if (adv && b3_vld_r) begin
      if (b3_close_r) begin
        row_r <= row_nxt;
        for (int i = 0; i < MAX_DOF; i++) begin
          acc_r[i] <= '0;
        end
      end else begin
        for (int i = 0; i < MAX_DOF; i++) begin
          acc_r[i] <= acc_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_close) begin
      emit_n_r   <= cfg.out_dof;
      emit_row_r <= row_r;
      for (int i = 0; i < MAX_DOF; i++) begin
        snap_r[i] <= acc_upd[i];
      end
    end
  end

  assign oq_push   = emit_busy_r & ~oq_full;
  assign emit_last = (emit_idx_r == emit_n_r - DOF_W'(1));

  always_comb begin
    emit_busy_nxt = emit_busy_r;
    emit_idx_nxt  = emit_idx_r;
    if (row_close) begin
      emit_busy_nxt = 1'b1;
      emit_idx_nxt  = '0;
    end else if (oq_push) begin
      emit_idx_nxt = emit_idx_r + DOF_W'(1);
      if (emit_last) begin
        emit_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_busy_r <= 1'b0;
      emit_idx_r  <= '0;
    end else begin
      emit_busy_r <= emit_busy_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  assign acc_e = snap_r[AIW'(emit_idx_r)];

  always_comb begin
    oq_item.row  = emit_row_r;
    oq_item.comp = COMP_W'(emit_idx_r);
    oq_item.last = emit_last;
    if (acc_e > Q_MAX_ACC) begin
      oq_item.sum       = Q_MAX;
      oq_item.saturated = 1'b1;
    end else if (acc_e < Q_MIN_ACC) begin
      oq_item.sum       = Q_MIN;
      oq_item.saturated = 1'b1;
    end else begin
      oq_item.sum       = acc_e[Q_W-1:0];
      oq_item.saturated = 1'b0;
    end
  end

endmodule

>>> rtl/block_csr_sparse_matvec_unit.sv
// Top level of the block-CSR sparse matrix times vector unit.
//
//   Channel   Ports                              Moves
//   input     in_push, in_full, in_item          one load, coefficient or close item
//   result    out_empty, out_pop, out_item       one row component sum
//   config    cfg_we, cfg_index, cfg_wdata       out_dof, in_dof, row_count
//
// One item is accepted per cycle while in_full is low. A row close delivers out_dof
// results, one per cycle while oq_full is low, from a snapshot of the accumulators.
// A second close waits in the back pipeline until the previous row has been emitted.
// A full result queue stalls emission, then a pending close, the work queue and the input.
// A low rst_n clears all control state; the vector memory is not cleared.
module block_csr_sparse_matvec_unit
  import bcsr_pkg::*;
#(
  parameter int NODES       = NODES_DEF,
  parameter int MAX_DOF     = MAX_DOF_DEF,
  parameter int QUEUE_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  bcsr_in_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output bcsr_out_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  bcsr_cfg_t  cfg_r, cfg_nxt;
  bcsr_work_t f_work;
  bcsr_work_t b_work;
  bcsr_out_t  r_item;
  logic       wq_push, wq_full, wq_pop, wq_empty;
  logic       oq_push, oq_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_OUT_DOF:   cfg_nxt.out_dof   = eff_dof(cfg_wdata[CFG_DOF_W-1:0], DOF_W'(MAX_DOF));
        REG_IN_DOF:    cfg_nxt.in_dof    = eff_dof(cfg_wdata[CFG_DOF_W-1:0], DOF_W'(MAX_DOF));
        REG_ROW_COUNT: cfg_nxt.row_count = cfg_wdata[ROWCNT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_dof   <= DOF_W'(1);
      cfg_r.in_dof    <= DOF_W'(1);
      cfg_r.row_count <= ROW_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bcsr_front #(
    .NODES   (NODES),
    .MAX_DOF (MAX_DOF)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (wq_full),
    .q_push  (wq_push),
    .q_work  (f_work)
  );

  bcsr_fifo #(
    .WIDTH ($bits(bcsr_work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wq_push),
    .wdata (f_work),
    .full  (wq_full),
    .pop   (wq_pop),
    .rdata (b_work),
    .empty (wq_empty)
  );

  bcsr_back #(
    .MAX_DOF (MAX_DOF)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (wq_empty),
    .q_work  (b_work),
    .q_pop   (wq_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_item (r_item)
  );

  bcsr_fifo #(
    .WIDTH ($bits(bcsr_out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (r_item),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

>>> rtl/bcsr_checker.sv
// Port-level assertion checker for the block-CSR matrix-vector unit and its bind.
module bcsr_checker
  import bcsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input bcsr_out_t out_item
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("Queues are not empty after reset.");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("A waiting result item changed before it was taken.");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.saturated |->
      out_item.sum == Q_MAX || out_item.sum == Q_MIN)
    else $error("A saturated result does not hold a range limit.");

  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && out_item.last |=> out_empty || out_item.comp == '0)
    else $error("A new row does not start at component zero.");

  a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && !out_item.last |=>
      out_empty || (out_item.comp == $past(out_item.comp) + 2'd1 &&
                    out_item.row == $past(out_item.row)))
    else $error("Components of a row are not delivered in order.");

endmodule

bind block_csr_sparse_matvec_unit bcsr_checker u_bcsr_checker (.*);
